// ===== rtl/mscr_pkg.sv =====
package mscr_pkg;

  // Width of a raw sensor word and of each calibration reference.
  localparam int SMP_W = 10;

  // Width of the measure interval register and of the tick counter.
  localparam int TPM_W = 16;
  localparam int TICK_W = 17;

  // Width of the signed moisture percentage.
  localparam int PCT_W = 18;

  // Shared divider widths: the dividend holds 100 times a sample difference
  // or a calibration sum, and the divisor holds a reference difference or
  // the number of calibration reads.
  localparam int DVD_W = 17;
  localparam int DVS_W = 10;

  // Default number of reads averaged into one reference.
  localparam int CAL_SAMPLES_DEF = 30;

  // Reset values of the tick counter, interval and references.
  localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(10000);
  localparam logic [TPM_W-1:0] TPM_RESET = TPM_W'(1);
  localparam logic [SMP_W-1:0] WET_RESET = SMP_W'(353);
  localparam logic [SMP_W-1:0] DRY_RESET = SMP_W'(1022);

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WET   = 2'd1,
    CMD_DRY   = 2'd2,
    CMD_RESET = 2'd3
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_PREP,
    ST_PCT,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/mscr_if.sv =====
// Input channel: one command word per item.
interface mscr_in_if;
  logic                           valid;
  logic                           ready;
  mscr_pkg::cmd_t                 command;
  logic [mscr_pkg::SMP_W-1:0]     sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink (input valid, input command, input sample, output ready);
endinterface

// Result channel: one result word per item.
interface mscr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           measured;
  logic [mscr_pkg::SMP_W-1:0]     last_sample;
  logic signed [mscr_pkg::PCT_W-1:0] percent;
  logic                           percent_valid;
  logic                           calib_done;
  logic [mscr_pkg::SMP_W-1:0]     wet_level;
  logic [mscr_pkg::SMP_W-1:0]     dry_level;

  modport source (output valid, output measured, output last_sample, output percent,
                  output percent_valid, output calib_done, output wet_level,
                  output dry_level, input ready);
  modport sink (input valid, input measured, input last_sample, input percent,
                input percent_valid, input calib_done, input wet_level,
                input dry_level, output ready);
endinterface

// Configuration channel: writes the measure interval.
interface mscr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mscr_pkg::TPM_W-1:0]     ticks_per_measure;

  modport source (output valid, output ticks_per_measure, input ready);
  modport sink (input valid, input ticks_per_measure, output ready);
endinterface

// ===== rtl/mscr_div.sv =====
module mscr_div #(
  parameter int DVD_W = mscr_pkg::DVD_W,
  parameter int DVS_W = mscr_pkg::DVS_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import mscr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = ~diff[DVS_W+1];

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNT_W'(DVD_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      rem_nxt  = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Step counter and done flag are control; the operands need no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/moisture_sensor_calibrated_reader.sv =====
// Channel  | Dir | Payload                                              | Accepted when
// in_ch    | in  | command, sample                                      | valid && ready
// out_ch   | out | measured, last_sample, percent, percent_valid,      | valid && ready
//          |     | calib_done, wet_level, dry_level                     |
// cfg_ch   | in  | ticks_per_measure                                    | valid && ready
//
// An accepted item passes through ST_PREP, which sets up the percentage, and
// ST_PCT, in which the shared restoring divider produces 17 quotient bits at
// one per cycle and then raises done; ST_DONE then loads the output register.
// The next item is not taken until the sequencer is back in ST_IDLE.
// A calibration read that completes the averaging buffer first runs the
// divider for the average in ST_AVG.
// Equal references skip the percentage division.
// Reset (rst_n low at a clock edge) restores the interval and references.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits until the output register is free, and the next item is then taken.
module moisture_sensor_calibrated_reader #(
  parameter int CAL_SAMPLES = mscr_pkg::CAL_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mscr_in_if.sink     in_ch,
  mscr_out_if.source  out_ch,
  mscr_cfg_if.sink    cfg_ch
);
  import mscr_pkg::*;

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = SMP_W + CNT_W;

  state_t state_r, state_nxt;

  logic [TPM_W-1:0]  tpm_r, tpm_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [SMP_W-1:0]  latched_r, latched_nxt;
  logic [SMP_W-1:0]  wet_r, wet_nxt;
  logic [SMP_W-1:0]  dry_r, dry_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  ccnt_r, ccnt_nxt;
  logic              to_dry_r, to_dry_nxt;
  logic              meas_r, meas_nxt;
  logic              cdone_r, cdone_nxt;
  logic              neg_r, neg_nxt;
  logic              pvalid_r, pvalid_nxt;
  logic signed [PCT_W-1:0] pct_r, pct_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_meas_r, out_cdone_r, out_pvalid_r;
  logic [SMP_W-1:0]  out_last_r, out_wet_r, out_dry_r;
  logic signed [PCT_W-1:0] out_pct_r;

  logic              in_fire;
  logic              out_load;
  logic [TICK_W-1:0] tick_inc;
  logic              tick_hit;
  logic [SUM_W-1:0]  sum_inc;
  logic [CNT_W-1:0]  ccnt_inc;
  logic              cal_full;
  logic              cal_cmd;
  logic              cal_fill;
  logic              den_neg;
  logic [SMP_W-1:0]  den_mag;
  logic              num_neg;
  logic [SMP_W-1:0]  diff_mag;
  logic [DVD_W-1:0]  diff_ext;
  logic [DVD_W-1:0]  num_mag;

  logic              div_start;
  logic [DVD_W-1:0]  div_dvd;
  logic [DVS_W-1:0]  div_dvs;
  logic              div_busy;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Tick counter update and sample-due compare.
  assign tick_inc = tick_r + TICK_W'(1);
  assign tick_hit = (tick_inc >= {1'b0, tpm_r});

  // Calibration buffer bookkeeping.
  assign sum_inc  = sum_r + {{CNT_W{1'b0}}, latched_r};
  assign ccnt_inc = ccnt_r + CNT_W'(1);
  assign cal_full = (ccnt_r >= CNT_W'(CAL_SAMPLES));
  assign cal_cmd  = (in_ch.command == CMD_WET) || (in_ch.command == CMD_DRY);
  assign cal_fill = cal_cmd && !cal_full && (ccnt_inc == CNT_W'(CAL_SAMPLES));

  // Signed operands of the percentage, split into sign and magnitude.
  assign den_neg  = (dry_r < wet_r);
  assign den_mag  = den_neg ? (wet_r - dry_r) : (dry_r - wet_r);
  assign num_neg  = (dry_r < latched_r);
  assign diff_mag = num_neg ? (latched_r - dry_r) : (dry_r - latched_r);
  assign diff_ext = DVD_W'(diff_mag);
  // Times 100 as 64 + 32 + 4.
  assign num_mag  = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

  // Shared divider for both the calibration average and the percentage.
  mscr_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = cal_fill ? ST_AVG : ST_PREP;
        end
      end
      ST_AVG: begin
        if (div_done) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = (den_mag != '0) ? ST_PCT : ST_DONE;
      end
      ST_PCT: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, divider control and result load.
  always_comb begin
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    div_dvd     = num_mag;
    div_dvs     = den_mag;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        div_dvd     = DVD_W'(sum_inc);
        div_dvs     = DVS_W'(CAL_SAMPLES);
        div_start   = in_fire && cal_fill;
      end
      ST_PREP: begin
        div_start = (den_mag != '0);
      end
      ST_DONE: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  // Block state updates.
  always_comb begin
    tpm_nxt     = tpm_r;
    tick_nxt    = tick_r;
    latched_nxt = latched_r;
    wet_nxt     = wet_r;
    dry_nxt     = dry_r;
    sum_nxt     = sum_r;
    ccnt_nxt    = ccnt_r;
    to_dry_nxt  = to_dry_r;
    meas_nxt    = meas_r;
    cdone_nxt   = cdone_r;
    neg_nxt     = neg_r;
    pvalid_nxt  = pvalid_r;
    pct_nxt     = pct_r;

    if (cfg_ch.valid && cfg_ch.ready) begin
      tpm_nxt = cfg_ch.ticks_per_measure;
    end

    if (in_fire) begin
      meas_nxt   = 1'b0;
      cdone_nxt  = 1'b0;
      to_dry_nxt = (in_ch.command == CMD_DRY);
      unique case (in_ch.command) inside
        CMD_TICK: begin
          if (tick_hit) begin
            tick_nxt    = '0;
            latched_nxt = in_ch.sample;
            meas_nxt    = 1'b1;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        CMD_WET, CMD_DRY: begin
          if (!cal_full) begin
            sum_nxt  = sum_inc;
            ccnt_nxt = ccnt_inc;
          end
        end
        CMD_RESET: begin
          sum_nxt  = '0;
          ccnt_nxt = '0;
        end
        default: begin
        end
      endcase
    end

    // The average replaces the reference that the read was aimed at.
    if (state_r == ST_AVG && div_done) begin
      cdone_nxt = 1'b1;
      if (to_dry_r) begin
        dry_nxt = div_quo[SMP_W-1:0];
      end else begin
        wet_nxt = div_quo[SMP_W-1:0];
      end
    end

    // Equal references give a zero, invalid percentage.
    if (state_r == ST_PREP) begin
      pct_nxt    = '0;
      pvalid_nxt = (den_mag != '0);
      neg_nxt    = num_neg ^ den_neg;
    end

    // Truncation toward zero: divide magnitudes, then apply the sign.
    if (state_r == ST_PCT && div_done) begin
      pct_nxt = neg_r ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    end
  end

  // Output register keeps the result until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and calibration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tpm_r       <= TPM_RESET;
      tick_r      <= TICK_RESET;
      latched_r   <= '0;
      wet_r       <= WET_RESET;
      dry_r       <= DRY_RESET;
      sum_r       <= '0;
      ccnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tpm_r       <= tpm_nxt;
      tick_r      <= tick_nxt;
      latched_r   <= latched_nxt;
      wet_r       <= wet_nxt;
      dry_r       <= dry_nxt;
      sum_r       <= sum_nxt;
      ccnt_r      <= ccnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    to_dry_r <= to_dry_nxt;
    meas_r   <= meas_nxt;
    cdone_r  <= cdone_nxt;
    neg_r    <= neg_nxt;
    pvalid_r <= pvalid_nxt;
    pct_r    <= pct_nxt;
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_meas_r   <= meas_r;
      out_last_r   <= latched_r;
      out_pct_r    <= pct_r;
      out_pvalid_r <= pvalid_r;
      out_cdone_r  <= cdone_r;
      out_wet_r    <= wet_r;
      out_dry_r    <= dry_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.measured      = out_meas_r;
  assign out_ch.last_sample   = out_last_r;
  assign out_ch.percent       = out_pct_r;
  assign out_ch.percent_valid = out_pvalid_r;
  assign out_ch.calib_done    = out_cdone_r;
  assign out_ch.wet_level     = out_wet_r;
  assign out_ch.dry_level     = out_dry_r;

  // An accepted word always starts the sequencer.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("sequencer stayed idle after accepting a word");

  // The divider is never restarted while it is still working.
  a_div_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // The calibration count never passes the buffer size.
  a_cal_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ccnt_r <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count overran the buffer");

  // An invalid percentage is reported as zero.
  a_invalid_pct_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.percent_valid |-> out_ch.percent == '0)
    else $error("invalid percentage is not zero");

endmodule

// ===== test/tb_moisture_sensor_calibrated_reader.sv =====
`timescale 1ns / 1ps

module tb_moisture_sensor_calibrated_reader;

  import mscr_pkg::*;

  localparam int PCT_SCALE = 100;
  localparam int CHOKE_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;

  // One input word and one predicted reading.
  typedef struct packed {
    cmd_t              command;
    logic [SMP_W-1:0]  sample;
  } sensor_word_t;

  typedef struct packed {
    logic                     measured;
    logic [SMP_W-1:0]         last_sample;
    logic signed [PCT_W-1:0]  percent;
    logic                     percent_valid;
    logic                     calib_done;
    logic [SMP_W-1:0]         wet_level;
    logic [SMP_W-1:0]         dry_level;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n;

  mscr_in_if in_ch ();
  mscr_out_if out_ch ();
  mscr_cfg_if cfg_ch ();

  moisture_sensor_calibrated_reader DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be sent, and readings waiting to come back.
  sensor_word_t word_q[$];
  reading_t reading_q[$];
  int unsigned queued_words = 0;
  int bad_results = 0;
  int choke_req = 0;

  // Sensor state as the block should hold it.
  logic [TPM_W-1:0]  interval;
  logic [TICK_W-1:0] tick_cnt;
  logic [SMP_W-1:0]  held_sample;
  logic [SMP_W-1:0]  wet_ref;
  logic [SMP_W-1:0]  dry_ref;
  logic [14:0]       cal_sum;
  logic [4:0]        cal_cnt;

  // Advances the sensor state by one word and returns the reading it yields.
  function automatic reading_t predict_reading(cmd_t cmd, logic [SMP_W-1:0] smp);
    reading_t r;
    longint span;
    longint pct;
    r = '0;
    case (cmd) inside
      CMD_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= TICK_W'(interval)) begin
          tick_cnt = '0;
          held_sample = smp;
          r.measured = 1'b1;
        end
      end
      CMD_WET, CMD_DRY: begin
        // A full buffer ignores further reads until a reset command.
        if (cal_cnt < CAL_SAMPLES_DEF) begin
          cal_sum = cal_sum + held_sample;
          cal_cnt = cal_cnt + 1'b1;
          if (cal_cnt == CAL_SAMPLES_DEF) begin
            if (cmd == CMD_WET) begin
              wet_ref = SMP_W'(cal_sum / CAL_SAMPLES_DEF);
            end else begin
              dry_ref = SMP_W'(cal_sum / CAL_SAMPLES_DEF);
            end
            r.calib_done = 1'b1;
          end
        end
      end
      default: begin
        cal_cnt = '0;
        cal_sum = '0;
      end
    endcase

    // Two-point percentage, truncated toward zero; equal references give zero.
    span = longint'(dry_ref) - longint'(wet_ref);
    if (span != 0) begin
      pct = (longint'(dry_ref) - longint'(held_sample)) * PCT_SCALE / span;
      if (pct > 131071) pct = 131071;
      if (pct < -131072) pct = -131072;
      r.percent = PCT_W'(pct);
      r.percent_valid = 1'b1;
    end
    r.last_sample = held_sample;
    r.wet_level = wet_ref;
    r.dry_level = dry_ref;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void queue_word(cmd_t cmd, int unsigned smp);
    sensor_word_t w;
    w.command = cmd;
    w.sample = SMP_W'(smp);
    word_q.push_back(w);
    queued_words++;
  endfunction

  // Driver: offers queued words and predicts each one as it is accepted.
  int unsigned feed_gap = 0;
  bit feed_calm = 1'b0;

  always @(posedge clk) begin : feed
    sensor_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      feed_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        reading_q.push_back(predict_reading(in_ch.command, in_ch.sample));
      end
      if (in_ch.valid && !in_ch.ready) begin
        // The offered word stays on the channel until it is taken.
      end else if (feed_gap > 0) begin
        feed_gap--;
        in_ch.valid <= 1'b0;
      end else if (word_q.size() != 0) begin
        w = word_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= w.command;
        in_ch.sample <= w.sample;
        feed_gap = pick_gap(feed_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
      if ($urandom_range(0, 299) == 0) feed_calm = !feed_calm;
    end
  end

  // Receiver back-pressure, with a long hold-off on request.
  int unsigned sink_stall = 0;
  int choke_seen = 0;
  bit sink_calm = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_stall = 0;
    end else if (choke_seen != choke_req) begin
      choke_seen = choke_req;
      sink_stall = CHOKE_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      sink_stall = pick_gap(sink_calm);
    end
    if ($urandom_range(0, 299) == 0) sink_calm = !sink_calm;
  end

  task automatic check_field(string name, integer want, integer got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      bad_results++;
    end
  endtask

  // Monitor: each accepted reading is checked against the oldest prediction.
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reading_q.size() == 0) begin
        $display("%0t: reading with none expected, last_sample %0d", $time,
                 out_ch.last_sample);
        bad_results++;
      end else begin
        want = reading_q.pop_front();
        check_field("measured", want.measured, out_ch.measured);
        check_field("last_sample", want.last_sample, out_ch.last_sample);
        check_field("percent", $signed(want.percent), $signed(out_ch.percent));
        check_field("percent_valid", want.percent_valid, out_ch.percent_valid);
        check_field("calib_done", want.calib_done, out_ch.calib_done);
        check_field("wet_level", want.wet_level, out_ch.wet_level);
        check_field("dry_level", want.dry_level, out_ch.dry_level);
      end
    end
  end

  // Watchdog: too long without any word moving on any channel.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until every queued word has gone out and every reading has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (word_q.size() != 0 || reading_q.size() != 0 || in_ch.valid);
  endtask

  task automatic write_interval(logic [TPM_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.ticks_per_measure <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    interval = value;
  endtask

  // Mostly calibration runs with random content, plus equal-reference runs
  // and short bursts of arbitrary words.
  task automatic queue_phase(int unsigned count, bit equal_refs);
    int unsigned target;
    int unsigned reads;
    int unsigned level;
    int unsigned roll;
    cmd_t kind;
    target = queued_words + count;
    if (equal_refs) begin
      // Both references averaged from one latched level.
      level = $urandom_range(0, 1023);
      queue_word(CMD_TICK, level);
      queue_word(CMD_RESET, $urandom_range(0, 1023));
      repeat (CAL_SAMPLES_DEF) queue_word(CMD_WET, $urandom_range(0, 1023));
      queue_word(CMD_RESET, $urandom_range(0, 1023));
      repeat (CAL_SAMPLES_DEF) queue_word(CMD_DRY, $urandom_range(0, 1023));
      queue_word(CMD_TICK, $urandom_range(0, 1023));
    end
    while (queued_words < target) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
        queue_word(CMD_RESET, $urandom_range(0, 1023));
        kind = $urandom_range(0, 1) ? CMD_WET : CMD_DRY;
        reads = $urandom_range(27, 33);
        while (reads > 0) begin
          if ($urandom_range(0, 3) == 0) begin
            queue_word(CMD_TICK, $urandom_range(0, 1023));
          end else begin
            queue_word(kind, $urandom_range(0, 1023));
            reads--;
          end
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          queue_word(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023));
        end
      end
    end
  endtask

  initial begin
    int unsigned plan [7];
    int p;

    // Known levels on every input, then reset.
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.ticks_per_measure = '0;

    interval = TPM_RESET;
    tick_cnt = TICK_RESET;
    held_sample = '0;
    wet_ref = WET_RESET;
    dry_ref = DRY_RESET;
    cal_sum = '0;
    cal_cnt = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: the first tick measures, sample extremes, every command.
    queue_word(CMD_TICK, 0);
    queue_word(CMD_TICK, 1023);
    queue_word(CMD_TICK, 'h2AA);
    queue_word(CMD_TICK, 'h155);
    queue_word(CMD_WET, 'h3FF);
    queue_word(CMD_DRY, 0);
    queue_word(CMD_RESET, 'h3FF);
    queue_word(CMD_TICK, 353);
    queue_word(CMD_TICK, 1022);
    queue_word(CMD_WET, 0);
    queue_word(CMD_RESET, 0);
    queue_word(CMD_DRY, 'h155);

    // A zero interval latches on every tick.
    write_interval(TPM_W'(0));
    repeat (3) queue_word(CMD_TICK, $urandom_range(0, 1023));

    // The widest interval lets the count grow without latching.
    write_interval(TPM_W'(16'hFFFF));
    repeat (4) queue_word(CMD_TICK, $urandom_range(0, 1023));

    // Lowering the interval below the count latches on the next tick.
    write_interval(TPM_W'(2));
    repeat (3) queue_word(CMD_TICK, $urandom_range(0, 1023));

    // Random phases over several intervals.
    plan = '{1, 0, 16'hFFFF, 0, 1, 0, 1};
    plan[3] = $urandom_range(2, 9);
    for (p = 0; p < 7; p++) begin
      write_interval(TPM_W'(plan[p]));
      @(negedge clk);
      queue_phase(95, plan[p] <= 1);
      // Hold the receiver off while words keep coming, so the block backs up.
      if (p == 1) choke_req++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
